// ----- hdl/stf_pkg.sv -----
// Shared constants for the four-point circumsphere pipeline.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps
package stf_pkg;

    localparam int IN_W           = 12;
    localparam int OUT_W          = 40;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int Q_W            = 42;
    localparam int HALF_W         = Q_W / 2;
    localparam int ROOT_W         = 42;

endpackage

// ----- hdl/stf_if.sv -----
// Valid/ready channels for point quadruples and sphere results.
// Depends on stf_pkg for the field widths.
`timescale 1ns / 1ps
interface stf_in_if;
    import stf_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] ax;
    logic [IN_W-1:0] ay;
    logic [IN_W-1:0] az;
    logic [IN_W-1:0] bx;
    logic [IN_W-1:0] by_coord;
    logic [IN_W-1:0] bz;
    logic [IN_W-1:0] cx;
    logic [IN_W-1:0] cy;
    logic [IN_W-1:0] cz;
    logic [IN_W-1:0] dx;
    logic [IN_W-1:0] dy;
    logic [IN_W-1:0] dz;

    modport source (
        output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz,
        input  ready
    );
    modport sink (
        input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz,
        output ready
    );
endinterface

interface stf_out_if;
    import stf_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] center_x;
    logic [OUT_W-1:0] center_y;
    logic [OUT_W-1:0] center_z;
    logic [OUT_W-1:0] radius;
    logic             degenerate;

    modport source (
        output valid, center_x, center_y, center_z, radius, degenerate,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, radius, degenerate,
        output ready
    );
endinterface

// ----- hdl/sphere_through_four_points.sv -----
// Channel  | dir | payload
// points   | in  | ax ay az bx by_coord bz cx cy cz dx dy dz (12b signed)
// sphere   | out | center_x/y/z (40b signed), radius (40b), degenerate
// One item enters per cycle while sphere is not stalled; the divider and square
// root resolve one bit per stage.
// Reset clears only the valid bits. A stall on sphere freezes every stage.
// Top level of the circumsphere pipeline; uses stf_pkg, stf_if, stf_div, stf_sqrt.
`timescale 1ns / 1ps
module sphere_through_four_points #(
    parameter int COORD_BITS = stf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = stf_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    stf_in_if.sink    points,
    stf_out_if.source sphere
);
    import stf_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int UW    = CB + 1;
    localparam int MW    = 2 * UW;
    localparam int BW    = 2 * CB + 2;
    localparam int CW    = 2 * CB + 2;
    localparam int NPW   = BW + 1 + CW;
    localparam int DPW   = UW + CW;
    localparam int NW    = 4 * CB + 6;
    localparam int DW    = 3 * CB + 4;
    localparam int NMX   = Q_W + DW;
    localparam int CTW   = 44;
    localparam int SW    = 2 * ROOT_W;
    localparam int DSB   = 3 * CB + 4;
    localparam int SSB   = 3 * OUT_W + 1;
    localparam logic [Q_W-1:0] QCLAMP = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [CTW-1:0] SMAX = CTW'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [CTW-1:0] SMIN = ~SMAX;
    localparam logic [ROOT_W:0] RMAX = (ROOT_W+1)'({OUT_W{1'b1}});

    logic en;
    assign en           = !sphere.valid || sphere.ready;
    assign points.ready = en;

    logic signed [CB-1:0] pt [4][3];
    assign pt[0][0] = points.ax[CB-1:0];
    assign pt[0][1] = points.ay[CB-1:0];
    assign pt[0][2] = points.az[CB-1:0];
    assign pt[1][0] = points.bx[CB-1:0];
    assign pt[1][1] = points.by_coord[CB-1:0];
    assign pt[1][2] = points.bz[CB-1:0];
    assign pt[2][0] = points.cx[CB-1:0];
    assign pt[2][1] = points.cy[CB-1:0];
    assign pt[2][2] = points.cz[CB-1:0];
    assign pt[3][0] = points.dx[CB-1:0];
    assign pt[3][1] = points.dy[CB-1:0];
    assign pt[3][2] = points.dz[CB-1:0];

    // stage registers
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, ov_reg;
    logic dq_valid;
    logic sr_valid;

    logic signed [UW-1:0]  u1_reg   [3][3];
    logic signed [CB-1:0]  a1_reg   [3];
    logic signed [MW-1:0]  sq2_reg  [3][3];
    logic signed [MW-1:0]  m12_reg  [3][3];
    logic signed [MW-1:0]  m22_reg  [3][3];
    logic signed [UW-1:0]  u02_reg  [3];
    logic signed [CB-1:0]  a2_reg   [3];
    logic [BW-1:0]         b3_reg   [3];
    logic signed [CW-1:0]  cof3_reg [3][3];
    logic signed [UW-1:0]  u03_reg  [3];
    logic signed [CB-1:0]  a3_reg   [3];
    logic signed [NPW-1:0] bp4_reg  [3][3];
    logic signed [DPW-1:0] dp4_reg  [3];
    logic signed [CB-1:0]  a4_reg   [3];
    logic signed [NW-1:0]  n5_reg   [3];
    logic signed [DW-1:0]  det5_reg;
    logic signed [CB-1:0]  a5_reg   [3];
    logic [NMX-1:0]        nm6_reg  [3];
    logic [DW-1:0]         dv6_reg;
    logic [2:0]            sgn6_reg;
    logic                  deg6_reg;
    logic signed [CB-1:0]  a6_reg   [3];
    logic [Q_W-1:0]        qm7_reg  [3];
    logic [OUT_W-1:0]      cen7_reg [3];
    logic                  deg7_reg;
    logic [2*HALF_W-1:0]   hh8_reg  [3];
    logic [2*HALF_W-1:0]   hl8_reg  [3];
    logic [2*HALF_W-1:0]   ll8_reg  [3];
    logic [OUT_W-1:0]      cen8_reg [3];
    logic                  deg8_reg;
    logic [SW-1:0]         sq9_reg  [3];
    logic [OUT_W-1:0]      cen9_reg [3];
    logic                  deg9_reg;
    logic [SW-1:0]         s10_reg;
    logic [OUT_W-1:0]      cen10_reg [3];
    logic                  deg10_reg;
    logic [OUT_W-1:0]      cx_reg, cy_reg, cz_reg, rad_reg;
    logic                  dg_reg;

    // next values
    logic signed [UW-1:0]  u1_next   [3][3];
    logic signed [MW-1:0]  sq2_next  [3][3];
    logic signed [MW-1:0]  m12_next  [3][3];
    logic signed [MW-1:0]  m22_next  [3][3];
    logic [BW-1:0]         b3_next   [3];
    logic signed [CW-1:0]  cof3_next [3][3];
    logic signed [NPW-1:0] bp4_next  [3][3];
    logic signed [DPW-1:0] dp4_next  [3];
    logic signed [NW-1:0]  n5_next   [3];
    logic signed [DW-1:0]  det5_next;
    logic [NW-1:0]         nabs      [3];
    logic [DW-1:0]         dmag;
    logic [NMX-1:0]        nm6_next  [3];
    logic [2:0]            sgn6_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                u1_next[i][k] = UW'(pt[i+1][k]) - UW'(pt[0][k]);
                sq2_next[i][k] = u1_reg[i][k] * u1_reg[i][k];
                m12_next[i][k] = u1_reg[(i+1)%3][(k+1)%3] * u1_reg[(i+2)%3][(k+2)%3];
                m22_next[i][k] = u1_reg[(i+1)%3][(k+2)%3] * u1_reg[(i+2)%3][(k+1)%3];
                cof3_next[i][k] = CW'(m12_reg[i][k] - m22_reg[i][k]);
                bp4_next[i][k] = $signed({1'b0, b3_reg[i]}) * cof3_reg[i][k];
            end
            b3_next[i] = BW'($unsigned(sq2_reg[i][0])) + BW'($unsigned(sq2_reg[i][1]))
                       + BW'($unsigned(sq2_reg[i][2]));
            dp4_next[i] = u03_reg[i] * cof3_reg[0][i];
            n5_next[i] = NW'(bp4_reg[0][i]) + NW'(bp4_reg[1][i]) + NW'(bp4_reg[2][i]);
        end
        det5_next = DW'(dp4_reg[0]) + DW'(dp4_reg[1]) + DW'(dp4_reg[2]);
        dmag = det5_reg[DW-1] ? DW'($unsigned(-det5_reg)) : DW'($unsigned(det5_reg));
        for (int k = 0; k < 3; k++)
        begin
            nabs[k] = n5_reg[k][NW-1] ? NW'($unsigned(-n5_reg[k])) : NW'($unsigned(n5_reg[k]));
            nm6_next[k] = (NMX'(nabs[k]) << FRAC_BITS) + NMX'(dmag);
            sgn6_next[k] = n5_reg[k][NW-1] ^ det5_reg[DW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= points.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= dq_valid;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            ov_reg  <= sr_valid;
        end
    end

    // front end: differences, products, cofactors, numerators, determinant, divider operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg    <= u1_next;
            a1_reg    <= pt[0];
            sq2_reg   <= sq2_next;
            m12_reg   <= m12_next;
            m22_reg   <= m22_next;
            u02_reg   <= u1_reg[0];
            a2_reg    <= a1_reg;
            b3_reg    <= b3_next;
            cof3_reg  <= cof3_next;
            u03_reg   <= u02_reg;
            a3_reg    <= a2_reg;
            bp4_reg   <= bp4_next;
            dp4_reg   <= dp4_next;
            a4_reg    <= a3_reg;
            n5_reg    <= n5_next;
            det5_reg  <= det5_next;
            a5_reg    <= a4_reg;
            nm6_reg   <= nm6_next;
            dv6_reg   <= dmag << 1;
            sgn6_reg  <= sgn6_next;
            deg6_reg  <= (det5_reg == '0);
            a6_reg    <= a5_reg;
        end
    end

    // divide
    logic [Q_W-1:0]    dq_quo [3];
    logic [2:0]        dq_ovf;
    logic [DSB-1:0]    dq_side;
    logic signed [CB-1:0] da [3];
    logic [2:0]        dsgn;
    logic              ddeg;

    stf_div #(
        .DVW (DW),
        .QW  (Q_W),
        .SBW (DSB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (nm6_reg),
        .den       (dv6_reg),
        .in_side   ({a6_reg[0], a6_reg[1], a6_reg[2], sgn6_reg, deg6_reg}),
        .out_valid (dq_valid),
        .quo       (dq_quo),
        .ovf       (dq_ovf),
        .out_side  (dq_side)
    );

    assign da[0] = dq_side[DSB-1 -: CB];
    assign da[1] = dq_side[DSB-1-CB -: CB];
    assign da[2] = dq_side[DSB-1-2*CB -: CB];
    assign dsgn  = dq_side[3:1];
    assign ddeg  = dq_side[0];

    // back end: clamp, center, squares of offsets and their sum
    logic [Q_W-1:0]          qm7_next  [3];
    logic signed [Q_W:0]     qs        [3];
    logic signed [CTW-1:0]   csum      [3];
    logic [OUT_W-1:0]        cen7_next [3];
    logic [SW-1:0]           sq9_next  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qm7_next[k] = (dq_ovf[k] || dq_quo[k] > QCLAMP) ? QCLAMP : dq_quo[k];
            qs[k] = dsgn[k] ? -$signed({1'b0, qm7_next[k]}) : $signed({1'b0, qm7_next[k]});
            csum[k] = (CTW'(da[k]) <<< FRAC_BITS) + CTW'(qs[k]);
            if (csum[k] > SMAX)
            begin
                cen7_next[k] = SMAX[OUT_W-1:0];
            end
            else if (csum[k] < SMIN)
            begin
                cen7_next[k] = SMIN[OUT_W-1:0];
            end
            else
            begin
                cen7_next[k] = csum[k][OUT_W-1:0];
            end
            sq9_next[k] = (SW'(hh8_reg[k]) << (2*HALF_W)) + (SW'(hl8_reg[k]) << (HALF_W+1))
                        + SW'(ll8_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qm7_reg  <= qm7_next;
            cen7_reg <= cen7_next;
            deg7_reg <= ddeg;
            for (int k = 0; k < 3; k++)
            begin
                hh8_reg[k] <= qm7_reg[k][Q_W-1:HALF_W] * qm7_reg[k][Q_W-1:HALF_W];
                hl8_reg[k] <= qm7_reg[k][Q_W-1:HALF_W] * qm7_reg[k][HALF_W-1:0];
                ll8_reg[k] <= qm7_reg[k][HALF_W-1:0] * qm7_reg[k][HALF_W-1:0];
            end
            cen8_reg  <= cen7_reg;
            deg8_reg  <= deg7_reg;
            sq9_reg   <= sq9_next;
            cen9_reg  <= cen8_reg;
            deg9_reg  <= deg8_reg;
            s10_reg   <= sq9_reg[0] + sq9_reg[1] + sq9_reg[2];
            cen10_reg <= cen9_reg;
            deg10_reg <= deg9_reg;
        end
    end

    // square root
    logic [ROOT_W-1:0] sr_root;
    logic [ROOT_W+1:0] sr_rem;
    logic [SSB-1:0]    sr_side;
    logic [ROOT_W:0]   rr;

    stf_sqrt #(
        .ROOT_W (ROOT_W),
        .SBW    (SSB)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v10_reg),
        .rad       (s10_reg),
        .in_side   ({cen10_reg[0], cen10_reg[1], cen10_reg[2], deg10_reg}),
        .out_valid (sr_valid),
        .root      (sr_root),
        .rem       (sr_rem),
        .out_side  (sr_side)
    );

    assign rr = (ROOT_W+1)'(sr_root) + (ROOT_W+1)'(sr_rem > (ROOT_W+2)'(sr_root));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sr_side[0])
            begin
                cx_reg  <= '0;
                cy_reg  <= '0;
                cz_reg  <= '0;
                rad_reg <= '0;
            end
            else
            begin
                cx_reg  <= sr_side[SSB-1 -: OUT_W];
                cy_reg  <= sr_side[SSB-1-OUT_W -: OUT_W];
                cz_reg  <= sr_side[SSB-1-2*OUT_W -: OUT_W];
                rad_reg <= (rr > RMAX) ? RMAX[OUT_W-1:0] : rr[OUT_W-1:0];
            end
            dg_reg <= sr_side[0];
        end
    end

    assign sphere.valid      = ov_reg;
    assign sphere.center_x   = cx_reg;
    assign sphere.center_y   = cy_reg;
    assign sphere.center_z   = cz_reg;
    assign sphere.radius     = rad_reg;
    assign sphere.degenerate = dg_reg;

`ifndef SYNTH
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sphere.valid && sphere.degenerate |->
            sphere.radius == '0 && sphere.center_x == '0 &&
            sphere.center_y == '0 && sphere.center_z == '0)
        else $error("degenerate item with nonzero fields");
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v6_reg) && $stable(v10_reg))
        else $error("pipeline moved during a stall");
    a_deg_from_det: assert property (@(posedge clk) disable iff (!rst_n)
        en && v5_reg |=> v6_reg && deg6_reg == (dv6_reg == '0))
        else $error("degenerate flag disagrees with divisor");
`endif

endmodule

// ----- hdl/stf_div.sv -----
// Pipelined restoring divider, three numerators over one divisor, one
// quotient bit per stage. Flags quotients that need more than QW bits.
`timescale 1ns / 1ps
module stf_div #(
    parameter int DVW = 40,
    parameter int QW  = stf_pkg::Q_W,
    parameter int SBW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [QW+DVW-1:0]   num [3],
    input  logic [DVW-1:0]      den,
    input  logic [SBW-1:0]      in_side,
    output logic                out_valid,
    output logic [QW-1:0]       quo [3],
    output logic [2:0]          ovf,
    output logic [SBW-1:0]      out_side
);
    import stf_pkg::*;

    localparam int NS = QW + 1;

    logic           v_reg    [NS];
    logic [DVW-1:0] rem_reg  [NS][3];
    logic [QW-1:0]  low_reg  [NS][3];
    logic [DVW-1:0] den_reg  [NS];
    logic [2:0]     ovf_reg  [NS];
    logic [SBW-1:0] side_reg [NS];

    // load stage: split numerator, flag quotient overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= num[l][QW+DVW-1:QW];
                low_reg[0][l] <= num[l][QW-1:0];
                ovf_reg[0][l] <= (num[l][QW+DVW-1:QW] >= den);
            end
            den_reg[0]  <= den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 1; j < NS; j++)
    begin : g_step
        logic [DVW:0]   trial [3];
        logic [DVW:0]   diff  [3];
        logic [2:0]     ge;
        logic [DVW-1:0] rem_next [3];
        logic [QW-1:0]  low_next [3];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l]    = {rem_reg[j-1][l], low_reg[j-1][l][QW-1]};
                diff[l]     = trial[l] - {1'b0, den_reg[j-1]};
                ge[l]       = (trial[l] >= {1'b0, den_reg[j-1]});
                rem_next[l] = ge[l] ? diff[l][DVW-1:0] : trial[l][DVW-1:0];
                low_next[l] = {low_reg[j-1][l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[j][l] <= rem_next[l];
                    low_reg[j][l] <= low_next[l];
                end
                den_reg[j]  <= den_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign ovf       = ovf_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            quo[l] = low_reg[NS-1][l];
        end
    end

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] && den_reg[NS-1] != '0 |->
            (ovf_reg[NS-1][0] || rem_reg[NS-1][0] < den_reg[NS-1]) &&
            (ovf_reg[NS-1][1] || rem_reg[NS-1][1] < den_reg[NS-1]) &&
            (ovf_reg[NS-1][2] || rem_reg[NS-1][2] < den_reg[NS-1]))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ----- hdl/stf_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives floor root and remainder; carries a sideband along.
`timescale 1ns / 1ps
module stf_sqrt #(
    parameter int ROOT_W = stf_pkg::ROOT_W,
    parameter int SBW    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] rad,
    input  logic [SBW-1:0]      in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [ROOT_W+1:0]   rem,
    output logic [SBW-1:0]      out_side
);
    import stf_pkg::*;

    localparam int SW  = 2 * ROOT_W;
    localparam int RMW = ROOT_W + 2;

    logic              v_reg    [ROOT_W];
    logic [RMW-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SW-1:0]     sh_reg   [ROOT_W];
    logic [SBW-1:0]    side_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_step
        logic              p_v;
        logic [RMW-1:0]    p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SW-1:0]     p_sh;
        logic [SBW-1:0]    p_side;
        logic [RMW+1:0]    acc;
        logic [RMW+1:0]    sub;
        logic [RMW+1:0]    diff;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign p_v    = in_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_sh   = rad;
            assign p_side = in_side;
        end
        else
        begin : g_next
            assign p_v    = v_reg[j-1];
            assign p_rem  = rem_reg[j-1];
            assign p_root = root_reg[j-1];
            assign p_sh   = sh_reg[j-1];
            assign p_side = side_reg[j-1];
        end

        assign acc  = {p_rem, p_sh[SW-1:SW-2]};
        assign sub  = {2'b00, p_root, 2'b01};
        assign diff = acc - sub;
        assign ge   = (acc >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= p_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? diff[RMW-1:0] : acc[RMW-1:0];
                root_reg[j] <= {p_root[ROOT_W-2:0], ge};
                sh_reg[j]   <= {p_sh[SW-3:0], 2'b00};
                side_reg[j] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign rem       = rem_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

`ifndef SYNTH
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ROOT_W-1] |-> rem_reg[ROOT_W-1] <= RMW'({root_reg[ROOT_W-1], 1'b0}))
        else $error("root remainder exceeds twice the root");
`endif

endmodule
